>>> rtl/hps_pkg.sv
// ----------------------------------------------------------------------------
// hps_pkg
// Shared types and constants for the hold progress stepper: phase and event
// codes, register indexes, reset values and controller/datapath handshakes.
// ----------------------------------------------------------------------------
package hps_pkg;

    // Field and register widths
    localparam int DEB_W    = 8;
    localparam int PERIOD_W = 32;
    localparam int STEPS_W  = 8;
    localparam int HELD_W   = 32;
    localparam int IDX_W    = 8;
    localparam int EV_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    // Threshold product: period quotient times (step index + 1) fits in 40 bits
    localparam int THR_W    = 40;
    // Divider iteration counter must hold PERIOD_W itself
    localparam int DIV_CNT_W = $clog2(PERIOD_W + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LEVEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT  = 2'd3;

    // Configuration reset values
    localparam logic                RST_IDLE_LEVEL  = 1'b1;
    localparam logic [DEB_W-1:0]    RST_DEBOUNCE_MS = 8'd5;
    localparam logic [PERIOD_W-1:0] RST_PERIOD_MS   = 32'd1000;
    localparam logic [STEPS_W-1:0]  RST_STEP_COUNT  = 8'd4;

    localparam logic [HELD_W-1:0] HELD_MAX = {HELD_W{1'b1}};
    localparam logic [IDX_W-1:0]  IDX_MAX  = {IDX_W{1'b1}};

    // Button phase
    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_HELD     = 2'd2
    } phase_t;

    // Event codes
    typedef enum logic [EV_W-1:0] {
        EV_NONE  = 2'd0,
        EV_STEP  = 2'd1,
        EV_ABORT = 2'd2
    } event_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_DIV    = 2'd1,
        ST_MUL    = 2'd2,
        ST_UPDATE = 2'd3
    } ctrl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;    // latch the request payload
        logic div_start;  // start the step length division
        logic mul_en;     // register the threshold product
        logic update;     // commit state and load the result register
    } hps_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;   // quotient is ready
        logic out_ready;  // result register can take a new result
    } hps_status_t;

endpackage

>>> rtl/hps_div.sv
// ----------------------------------------------------------------------------
// hps_div
// Restoring divider: period by step count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hps_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [hps_pkg::PERIOD_W-1:0]  dividend,
    input  logic [hps_pkg::STEPS_W-1:0]   divisor,
    output logic [hps_pkg::PERIOD_W-1:0]  quotient,
    output logic                          done
);

    logic [hps_pkg::PERIOD_W-1:0]  quo_reg;
    logic [hps_pkg::PERIOD_W-1:0]  quo_next;
    logic [hps_pkg::STEPS_W-1:0]   rem_reg;
    logic [hps_pkg::STEPS_W-1:0]   rem_next;
    logic [hps_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [hps_pkg::DIV_CNT_W-1:0] cnt_next;
    logic [hps_pkg::STEPS_W:0]     trial;
    logic                          fits;

    // Shift the next dividend bit into the partial remainder and try subtract
    assign trial = {rem_reg, quo_reg[hps_pkg::PERIOD_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = hps_pkg::DIV_CNT_W'(hps_pkg::PERIOD_W);
        end
        else if (cnt_reg != '0)
        begin
            quo_next = {quo_reg[hps_pkg::PERIOD_W-2:0], fits};
            rem_next = fits ? hps_pkg::STEPS_W'(trial - {1'b0, divisor})
                            : trial[hps_pkg::STEPS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Hold the iteration count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // Advance quotient and remainder
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient = quo_reg;
    assign done     = (cnt_reg == '0);

endmodule

>>> rtl/hps_datapath.sv
// ----------------------------------------------------------------------------
// hps_datapath
// Configuration registers, button state, step threshold arithmetic and the
// result register.
// ----------------------------------------------------------------------------
module hps_datapath
(
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_write_en,
    input  logic [hps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hps_pkg::CFG_DATA_W-1:0]  cfg_data,
    // request payload
    input  logic                            pin_level,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [hps_pkg::EV_W-1:0]        event_code,
    output logic [hps_pkg::IDX_W-1:0]       step_index,
    // control
    input  hps_pkg::hps_cmd_t               cmd,
    output hps_pkg::hps_status_t            status
);

    // Configuration
    logic                           idle_level_reg;
    logic [hps_pkg::DEB_W-1:0]      debounce_reg;
    logic [hps_pkg::PERIOD_W-1:0]   period_reg;
    logic [hps_pkg::STEPS_W-1:0]    step_count_reg;

    // Button state
    hps_pkg::phase_t                phase_reg;
    hps_pkg::phase_t                phase_next;
    logic [hps_pkg::HELD_W-1:0]     held_reg;
    logic [hps_pkg::HELD_W-1:0]     held_next;
    logic [hps_pkg::IDX_W-1:0]      step_reg;
    logic [hps_pkg::IDX_W-1:0]      step_next;

    // Working values
    logic                           pin_reg;
    logic [hps_pkg::PERIOD_W-1:0]   step_len;
    logic                           div_done;
    logic [hps_pkg::IDX_W:0]        step_plus1;
    logic [hps_pkg::THR_W:0]        mul_full;
    logic [hps_pkg::THR_W-1:0]      thr_reg;
    logic                           released;
    logic [hps_pkg::HELD_W-1:0]     held_inc;
    hps_pkg::event_t                ev;
    logic [hps_pkg::IDX_W-1:0]      idx;

    // Result register
    logic                           out_valid_reg;
    logic                           out_valid_next;
    hps_pkg::event_t                ev_reg;
    logic [hps_pkg::IDX_W-1:0]      idx_reg;

    // Write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_level_reg <= hps_pkg::RST_IDLE_LEVEL;
            debounce_reg   <= hps_pkg::RST_DEBOUNCE_MS;
            period_reg     <= hps_pkg::RST_PERIOD_MS;
            step_count_reg <= hps_pkg::RST_STEP_COUNT;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                hps_pkg::CFG_IDLE_LEVEL:  idle_level_reg <= cfg_data[0];
                hps_pkg::CFG_DEBOUNCE_MS: debounce_reg   <= cfg_data[hps_pkg::DEB_W-1:0];
                hps_pkg::CFG_PERIOD_MS:   period_reg     <= cfg_data[hps_pkg::PERIOD_W-1:0];
                hps_pkg::CFG_STEP_COUNT:  step_count_reg <= cfg_data[hps_pkg::STEPS_W-1:0];
                default: ;
            endcase
        end
    end

    // Latch the request sample
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            pin_reg <= pin_level;
    end

    // Step length = period / step count
    hps_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (period_reg),
        .divisor  (step_count_reg),
        .quotient (step_len),
        .done     (div_done)
    );

    // Threshold = step length * (next step + 1), registered
    assign step_plus1 = {1'b0, step_reg} + 1'b1;
    assign mul_full   = (hps_pkg::THR_W+1)'(step_len) * (hps_pkg::THR_W+1)'(step_plus1);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            thr_reg <= mul_full[hps_pkg::THR_W-1:0];
    end

    // Next button state and event
    assign released = (pin_reg == idle_level_reg);

    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        step_next  = step_reg;
        ev         = hps_pkg::EV_NONE;
        idx        = '0;
        held_inc   = held_reg;
        if (step_count_reg != '0)
        begin
            // Saturating elapsed time while a press is in progress
            if ((phase_reg == hps_pkg::PH_DEBOUNCE || phase_reg == hps_pkg::PH_HELD)
                && held_reg != hps_pkg::HELD_MAX)
                held_inc = held_reg + 1'b1;
            held_next = held_inc;
            unique case (phase_reg)
                hps_pkg::PH_DEBOUNCE:
                begin
                    if (released)
                        phase_next = hps_pkg::PH_IDLE;
                    else if (held_inc >= hps_pkg::HELD_W'(debounce_reg))
                        phase_next = hps_pkg::PH_HELD;
                end
                hps_pkg::PH_HELD:
                begin
                    if (released)
                    begin
                        phase_next = hps_pkg::PH_IDLE;
                        // abort only while fewer than step_count - 1 steps have been emitted
                        if ({1'b0, step_reg} < {1'b0, step_count_reg} - 1'b1)
                            ev = hps_pkg::EV_ABORT;
                    end
                    else if (hps_pkg::THR_W'(held_inc) >= thr_reg)
                    begin
                        ev  = hps_pkg::EV_STEP;
                        idx = step_reg;
                        if (step_reg != hps_pkg::IDX_MAX)
                            step_next = step_reg + 1'b1;
                    end
                end
                default:
                begin
                    // idle, and the unused phase code acts as idle
                    step_next = '0;
                    if (!released)
                    begin
                        held_next  = '0;
                        phase_next = hps_pkg::PH_DEBOUNCE;
                    end
                    else
                    begin
                        phase_next = hps_pkg::PH_IDLE;
                    end
                end
            endcase
        end
    end

    // Commit button state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= hps_pkg::PH_IDLE;
            held_reg  <= '0;
            step_reg  <= '0;
        end
        else if (cmd.update)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            step_reg  <= step_next;
        end
    end

    // Report divider state and whether the result register can take a result
    assign status = '{div_done: div_done, out_ready: (!out_valid_reg || !out_stall)};

    // Result register: load on update, drop when taken downstream
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.update)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            ev_reg  <= ev;
            idx_reg <= idx;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_code = ev_reg;
    assign step_index = idx_reg;

endmodule

>>> rtl/hps_ctrl.sv
// ----------------------------------------------------------------------------
// hps_ctrl
// Controller: takes one request, runs the divide and multiply, then commits
// the state and the result once the result register is free.
// ----------------------------------------------------------------------------
module hps_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output hps_pkg::hps_cmd_t     cmd,
    input  hps_pkg::hps_status_t  status
);

    hps_pkg::ctrl_state_t state_reg;
    hps_pkg::ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= hps_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != hps_pkg::ST_IDLE);
        unique case (state_reg)
            hps_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture   = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = hps_pkg::ST_DIV;
                end
            end
            hps_pkg::ST_DIV:
            begin
                if (status.div_done)
                    state_next = hps_pkg::ST_MUL;
            end
            hps_pkg::ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = hps_pkg::ST_UPDATE;
            end
            hps_pkg::ST_UPDATE:
            begin
                // hold until the previous result has been taken
                if (status.out_ready)
                begin
                    cmd.update = 1'b1;
                    state_next = hps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hps_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/hold_progress_stepper_unit.sv
// ----------------------------------------------------------------------------
// hold_progress_stepper_unit
// Debounced button with timed progress steps, one pin sample per request.
// ----------------------------------------------------------------------------
// Sequence: an accepted request passes the bit-serial divider, the multiply
// and the commit before out_valid rises, later if out_stall holds the result.
// No new request is taken until the controller is back in idle.
// Reset: configuration returns to idle_level 1, debounce 5 ms, period
// 1000 ms, 4 steps; phase idle, elapsed time and step index zero.
module hold_progress_stepper_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration port
    input  logic                            cfg_write_en,
    input  logic [hps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hps_pkg::CFG_DATA_W-1:0]  cfg_data,
    // request channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            pin_level,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [hps_pkg::EV_W-1:0]        event_code,
    output logic [hps_pkg::IDX_W-1:0]       step_index
);

    hps_pkg::hps_cmd_t    cmd;
    hps_pkg::hps_status_t status;

    hps_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    hps_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pin_level    (pin_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_code   (event_code),
        .step_index   (step_index),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

>>> dv/hold_progress_stepper_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hold_progress_stepper_unit_test
// Drives one pin sample per request into the hold progress stepper and
// compares every result with a cycle-free model of the debounce, held-time
// and step logic. Several register settings are exercised, including the
// extremes, with random idling on the request and result sides.
// ----------------------------------------------------------------------------
module hold_progress_stepper_unit_test;

    localparam int CLK_HALF     = 10;
    localparam int MAX_GAP      = 15;
    localparam int DRAIN_CYCLES = 40;
    localparam int PRESS_SPAN   = 300;

    typedef struct {
        logic [hps_pkg::EV_W-1:0]  code;
        logic [hps_pkg::IDX_W-1:0] index;
    } step_event_t;

    // Model of the button logic and queue of the events it predicts
    class step_event_board;
        logic                         idle_level;
        logic [hps_pkg::DEB_W-1:0]    debounce_ms;
        logic [hps_pkg::PERIOD_W-1:0] period_ms;
        logic [hps_pkg::STEPS_W-1:0]  step_count;
        hps_pkg::phase_t              phase;
        logic [hps_pkg::HELD_W-1:0]   held_ms;
        logic [hps_pkg::IDX_W-1:0]    next_step;
        step_event_t                  expected_events[$];
        int                           failures;

        function new();
            idle_level  = hps_pkg::RST_IDLE_LEVEL;
            debounce_ms = hps_pkg::RST_DEBOUNCE_MS;
            period_ms   = hps_pkg::RST_PERIOD_MS;
            step_count  = hps_pkg::RST_STEP_COUNT;
            phase       = hps_pkg::PH_IDLE;
            held_ms     = '0;
            next_step   = '0;
            failures    = 0;
        endfunction

        function void set_register(logic [hps_pkg::CFG_IDX_W-1:0] index,
                                   logic [hps_pkg::CFG_DATA_W-1:0] value);
            case (index)
                hps_pkg::CFG_IDLE_LEVEL:  idle_level  = value[0];
                hps_pkg::CFG_DEBOUNCE_MS: debounce_ms = value[hps_pkg::DEB_W-1:0];
                hps_pkg::CFG_PERIOD_MS:   period_ms   = value[hps_pkg::PERIOD_W-1:0];
                hps_pkg::CFG_STEP_COUNT:  step_count  = value[hps_pkg::STEPS_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the model by one accepted pin sample
        function void note_tick(logic pin);
            logic                      released;
            step_event_t               want;
            logic [hps_pkg::THR_W-1:0] seg_len;
            logic [hps_pkg::THR_W-1:0] step_mult;
            logic [hps_pkg::THR_W-1:0] threshold;
            released   = (pin == idle_level);
            want.code  = hps_pkg::EV_NONE;
            want.index = '0;
            // zero steps freezes the whole state
            if (step_count != '0)
            begin
                if ((phase == hps_pkg::PH_DEBOUNCE || phase == hps_pkg::PH_HELD)
                    && held_ms != hps_pkg::HELD_MAX)
                    held_ms = held_ms + 1'b1;
                case (phase)
                    hps_pkg::PH_DEBOUNCE:
                    begin
                        if (released)
                            phase = hps_pkg::PH_IDLE;
                        else if (held_ms >= {24'd0, debounce_ms})
                            phase = hps_pkg::PH_HELD;
                    end
                    hps_pkg::PH_HELD:
                    begin
                        if (released)
                        begin
                            phase = hps_pkg::PH_IDLE;
                            if (int'(next_step) < int'(step_count) - 1)
                                want.code = hps_pkg::EV_ABORT;
                        end
                        else
                        begin
                            seg_len   = hps_pkg::THR_W'(period_ms / step_count);
                            step_mult = hps_pkg::THR_W'(next_step);
                            step_mult = step_mult + 1'b1;
                            threshold = seg_len * step_mult;
                            if ({8'd0, held_ms} >= threshold)
                            begin
                                want.code  = hps_pkg::EV_STEP;
                                want.index = next_step;
                                if (next_step != hps_pkg::IDX_MAX)
                                    next_step = next_step + 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        next_step = '0;
                        if (!released)
                        begin
                            held_ms = '0;
                            phase   = hps_pkg::PH_DEBOUNCE;
                        end
                        else
                            phase = hps_pkg::PH_IDLE;
                    end
                endcase
            end
            expected_events.push_back(want);
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_event(logic [hps_pkg::EV_W-1:0] code,
                                  logic [hps_pkg::IDX_W-1:0] index);
            step_event_t want;
            if (expected_events.size() == 0)
            begin
                $error("unexpected result: event_code %0d step_index %0d", code, index);
                failures++;
                return;
            end
            want = expected_events.pop_front();
            if (code !== want.code)
            begin
                $error("event_code: expected %0d, actual %0d", want.code, code);
                failures++;
            end
            if (index !== want.index)
            begin
                $error("step_index: expected %0d, actual %0d", want.index, index);
                failures++;
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_write_en;
    logic [hps_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [hps_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           in_valid;
    logic                           in_stall;
    logic                           pin_level;
    logic                           out_valid;
    logic                           out_stall;
    logic [hps_pkg::EV_W-1:0]       event_code;
    logic [hps_pkg::IDX_W-1:0]      step_index;

    step_event_board board;
    int              ticks_sent;
    bit              quiet;

    hold_progress_stepper_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pin_level    (pin_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_code   (event_code),
        .step_index   (step_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #15_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Write one register; the caller lowers the enable afterwards
    task automatic write_reg(logic [hps_pkg::CFG_IDX_W-1:0] index,
                             logic [hps_pkg::CFG_DATA_W-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index    <= index;
        cfg_data     <= value;
        board.set_register(index, value);
        @(negedge clk);
    endtask

    task automatic apply_setting(logic idle, logic [hps_pkg::DEB_W-1:0] deb,
                                 logic [hps_pkg::PERIOD_W-1:0] period,
                                 logic [hps_pkg::STEPS_W-1:0] steps);
        write_reg(hps_pkg::CFG_IDLE_LEVEL, {31'd0, idle});
        write_reg(hps_pkg::CFG_DEBOUNCE_MS, {24'd0, deb});
        write_reg(hps_pkg::CFG_PERIOD_MS, period);
        write_reg(hps_pkg::CFG_STEP_COUNT, {24'd0, steps});
        cfg_write_en <= 1'b0;
    endtask

    // Send one pin sample; enter and leave at a falling edge
    task automatic send_tick(logic pin);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        pin_level <= pin;
        do
            @(posedge clk);
        while (in_stall);
        board.note_tick(pin);
        ticks_sent++;
        @(negedge clk);
    endtask

    // Release for a while, then press; a noisy press bounces now and then
    task automatic hold_sequence(int press_len, int release_len, bit noisy);
        logic active;
        logic pin;
        active = ~board.idle_level;
        repeat (release_len) send_tick(board.idle_level);
        for (int i = 0; i < press_len; i++)
        begin
            pin = active;
            if (noisy && $urandom_range(0, 7) == 0)
                pin = ~active;
            send_tick(pin);
        end
    endtask

    // Hold off new requests until every predicted event has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (board.expected_events.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(logic idle, logic [hps_pkg::DEB_W-1:0] deb,
                             logic [hps_pkg::PERIOD_W-1:0] period,
                             logic [hps_pkg::STEPS_W-1:0] steps, int n_ticks);
        int start;
        int span;
        apply_setting(idle, deb, period, steps);
        span  = (period > PRESS_SPAN) ? PRESS_SPAN : int'(period);
        start = ticks_sent;
        while (ticks_sent - start < n_ticks)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            hold_sequence($urandom_range(0, int'(deb) + span + 8), $urandom_range(0, 5),
                          $urandom_range(0, 6) == 0);
        end
        drain();
    endtask

    // Result side: stall a random number of cycles, then take one result
    initial
    begin
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            board.check_event(event_code, step_index);
            @(negedge clk);
        end
    end

    initial
    begin
        board        = new();
        ticks_sent   = 0;
        quiet        = 1'b0;
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = hps_pkg::CFG_IDLE_LEVEL;
        cfg_data     = '0;
        in_valid     = 1'b0;
        pin_level    = 1'b1;
        out_stall    = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: active-high pin, no debounce, three steps of 3 ms
        apply_setting(1'b0, 8'd0, 32'd10, 8'd3);
        // press and release after the first step: abort
        hold_sequence(5, 2, 1'b0);
        // hold through all steps and past the last one
        hold_sequence(14, 1, 1'b0);
        // release after the last step: no abort
        hold_sequence(0, 2, 1'b0);
        drain();

        // Reset values written back explicitly
        run_phase(1'b1, hps_pkg::RST_DEBOUNCE_MS, hps_pkg::RST_PERIOD_MS,
                  hps_pkg::RST_STEP_COUNT, 100);
        run_phase(1'b0, 8'd0, 32'd10, 8'd3, 150);
        run_phase(1'b1, 8'd2, 32'd8, 8'd4, 150);
        // Longest debounce, single step
        run_phase(1'b1, 8'd255, 32'd40, 8'd1, 150);

        // Zero step length with most steps: one long hold saturates the index
        apply_setting(1'b0, 8'd1, 32'd0, 8'd255);
        hold_sequence(300, 2, 1'b0);
        drain();
        run_phase(1'b0, 8'd1, 32'd0, 8'd255, 50);

        // Largest period: thresholds out of reach, releases abort
        run_phase(1'b1, 8'd3, 32'hFFFF_FFFF, 8'd255, 60);
        // Zero steps: nothing moves
        run_phase(1'b0, 8'd4, 32'd20, 8'd0, 60);
        // Period shorter than step count
        run_phase(1'b1, 8'd0, 32'd5, 8'd7, 60);
        repeat (3)
            run_phase(1'($urandom_range(0, 1)), hps_pkg::DEB_W'($urandom_range(0, 12)),
                      $urandom_range(0, 60), hps_pkg::STEPS_W'($urandom_range(0, 12)), 80);

        if (board.failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> hold_progress_stepper_unit.f
rtl/hps_pkg.sv
rtl/hps_div.sv
rtl/hps_datapath.sv
rtl/hps_ctrl.sv
rtl/hold_progress_stepper_unit.sv
dv/hold_progress_stepper_unit_test.sv
